// ===== hw/rtl/refresh_cadence_pacer_macros.svh =====
// assertion macros shared by the refresh cadence pacer checkers
`ifndef REFRESH_CADENCE_PACER_MACROS_SVH
`define REFRESH_CADENCE_PACER_MACROS_SVH

// same-cycle implication, masked while reset is high
`define RCP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define RCP_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rcp_pkg.sv =====
// shared types, constants and helpers for the refresh cadence pacer
`timescale 1ns / 1ps

package rcp_pkg;

   // sizing
   localparam int MAX_MULTIPLE = 4;
   localparam int TIME_BITS    = 48;
   localparam int MULT_LIMIT   = (MAX_MULTIPLE > 7) ? 7 : MAX_MULTIPLE;
   localparam int MULT_W       = 3;
   localparam int INTERVAL_W   = 20;
   localparam int PROD_W       = INTERVAL_W + MULT_W;
   localparam int TARGET_W     = 48;
   localparam int REPEAT_W     = 8;
   localparam int CFG_W        = 20;
   localparam int SLACK_W      = 10;
   localparam int PROMOTE_W    = 4;
   localparam int CSR_IDX_W    = 3;

   // queue depths, powers of two
   localparam int ITEM_DEPTH   = 4;
   localparam int ITEM_PTR_W   = $clog2(ITEM_DEPTH);
   localparam int RSP_DEPTH    = 2;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);

   // opcodes
   localparam logic OP_OBSERVE = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_HIGH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC_WINDOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY_SLACK   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMOTE_COUNT = 3'd6;

   // register reset values
   localparam logic [CFG_W-1:0]     RST_FRAME_PERIOD  = 20'd16667;
   localparam logic [CFG_W-1:0]     RST_MATCH_LOW     = 20'd16340;
   localparam logic [CFG_W-1:0]     RST_MATCH_HIGH    = 20'd17006;
   localparam logic [CFG_W-1:0]     RST_MAX_INTERVAL  = 20'd100000;
   localparam logic [CFG_W-1:0]     RST_RESYNC_WINDOW = 20'd100000;
   localparam logic [SLACK_W-1:0]   RST_EARLY_SLACK   = 10'd1;
   localparam logic [PROMOTE_W-1:0] RST_PROMOTE_COUNT = 4'd8;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [MULT_W-1:0]    mult_type;

   typedef struct packed {
      logic [CFG_W-1:0]     frame_period;
      logic [CFG_W-1:0]     match_low;
      logic [CFG_W-1:0]     match_high;
      logic [CFG_W-1:0]     max_interval;
      logic [CFG_W-1:0]     resync_window;
      logic [SLACK_W-1:0]   early_slack;
      logic [PROMOTE_W-1:0] promote_count;
   } cfg_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic                is_advance;
      logic                invalid;
      mult_type            found;
      time_type            target;
      time_type            tgt_plus_fp;
      time_type            tgt_plus_slack;
      time_type            tgt_plus_2fp;
      logic                resync_wait;
      logic                resync_step_ok;
      logic [REPEAT_W-1:0] repeats;
   } item_type;

   typedef struct packed {
      logic     frame_due;
      mult_type locked_divisor;
      mult_type pending_divisor;
   } rsp_type;

   // a - b taken signed modulo 2^TIME_BITS is above zero
   function automatic logic time_after(time_type a, time_type b);
      time_type d;
      d = a - b;
      return (d != '0) && !d[TIME_BITS-1];
   endfunction

endpackage

// ===== hw/rtl/rcp_csr.sv =====
// configuration registers of the refresh cadence pacer
`timescale 1ns / 1ps

module rcp_csr
   import rcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_PERIOD:  cfg_in.frame_period  = csr_wdata;
            CSR_MATCH_LOW:     cfg_in.match_low     = csr_wdata;
            CSR_MATCH_HIGH:    cfg_in.match_high    = csr_wdata;
            CSR_MAX_INTERVAL:  cfg_in.max_interval  = csr_wdata;
            CSR_RESYNC_WINDOW: cfg_in.resync_window = csr_wdata;
            CSR_EARLY_SLACK:   cfg_in.early_slack   = csr_wdata[SLACK_W-1:0];
            CSR_PROMOTE_COUNT: cfg_in.promote_count = csr_wdata[PROMOTE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_period  <= RST_FRAME_PERIOD;
         cfg_ff.match_low     <= RST_MATCH_LOW;
         cfg_ff.match_high    <= RST_MATCH_HIGH;
         cfg_ff.max_interval  <= RST_MAX_INTERVAL;
         cfg_ff.resync_window <= RST_RESYNC_WINDOW;
         cfg_ff.early_slack   <= RST_EARLY_SLACK;
         cfg_ff.promote_count <= RST_PROMOTE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/rcp_front.sv =====
// front end: classifies a transaction and precomputes its state-free terms
`timescale 1ns / 1ps

module rcp_front
   import rcp_pkg::*;
(
   input  cfg_type               cfg,
   input  logic                  req_opcode,
   input  logic [INTERVAL_W-1:0] req_interval_us,
   input  logic                  req_interval_bad,
   input  logic [TARGET_W-1:0]   req_target_us,
   input  logic [REPEAT_W-1:0]   req_repeat_count,
   output item_type              item
);

   time_type             tgt;
   time_type             fp_t;
   logic [PROD_W-1:0]    prod;
   mult_type             found;

   // first multiple whose product lands in the match band
   always_comb begin
      found = '0;
      prod  = '0;
      for (int n = MULT_LIMIT; n >= 1; n--) begin
         prod = PROD_W'(req_interval_us) * PROD_W'(n);
         if (prod >= PROD_W'(cfg.match_low) && prod <= PROD_W'(cfg.match_high)) begin
            found = MULT_W'(n);
         end
      end
   end

   assign tgt  = time_type'(req_target_us);
   assign fp_t = time_type'(cfg.frame_period);

   // classification, copied fields and target-relative times used by the back end
   always_comb begin
      item                = '0;
      item.is_advance     = (req_opcode == OP_ADVANCE);
      item.invalid        = req_interval_bad || (req_interval_us == '0) ||
                            (req_interval_us > cfg.max_interval);
      item.found          = found;
      item.target         = tgt;
      item.tgt_plus_fp    = tgt + fp_t;
      item.tgt_plus_slack = tgt + time_type'(cfg.early_slack);
      item.tgt_plus_2fp   = tgt + (fp_t << 1);
      // fresh next time still ahead of target plus slack
      item.resync_wait    = {1'b0, cfg.frame_period} > (CFG_W + 1)'(cfg.early_slack);
      // a second period still lands after the target
      item.resync_step_ok = (cfg.frame_period != '0);
      item.repeats        = req_repeat_count;
   end

endmodule

// ===== hw/rtl/rcp_item_queue.sv =====
// short queue between front and back
`timescale 1ns / 1ps

module rcp_item_queue
   import rcp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type                mem_ff [ITEM_DEPTH];
   logic [ITEM_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ITEM_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ITEM_PTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (ITEM_PTR_W + 1)'(ITEM_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/rcp_back.sv =====
// back end: cadence state, lock promotion and frame pacing
`timescale 1ns / 1ps

module rcp_back
   import rcp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   input  item_type item,
   output logic     item_pop,
   input  logic     rsp_ready,
   output logic     rsp_push,
   output rsp_type  rsp
);

   localparam logic [PROMOTE_W-1:0] AGREE_MAX = '1;

   mult_type              cand_ff, cand_in;
   logic [PROMOTE_W-1:0]  agree_ff, agree_in;
   mult_type              locked_ff, locked_in;
   time_type              nft_ff, nft_in;

   logic                  take;
   logic                  due;
   logic [PROMOTE_W-1:0]  agree_base;
   logic [PROMOTE_W-1:0]  agree_next;

   time_type              fp_t;
   time_type              rw_t;
   time_type              d_fwd;
   time_type              d_back;
   time_type              d_step;
   time_type              nft_step;
   logic                  near;
   logic                  resync;
   logic                  keep_wait;
   logic                  keep_step_ok;

   assign take     = item_valid && rsp_ready;
   assign item_pop = take;
   assign rsp_push = take;

   // wrapped distances against the kept next frame time
   assign fp_t         = time_type'(cfg.frame_period);
   assign rw_t         = time_type'(cfg.resync_window);
   assign d_fwd        = item.target - nft_ff;
   assign d_back       = nft_ff - item.target;
   assign d_step       = d_back + fp_t;
   assign nft_step     = nft_ff + fp_t;
   assign near         = (d_fwd <= rw_t) || (d_back <= rw_t);
   assign resync       = (nft_ff == '0) || !near;
   assign keep_wait    = time_after(nft_ff, item.tgt_plus_slack);
   assign keep_step_ok = (d_step != '0) && !d_step[TIME_BITS-1];

   // promotion counter
   always_comb begin
      agree_base = (item.found != cand_ff) ? '0 : agree_ff;
      agree_next = (agree_base != AGREE_MAX) ? agree_base + 1'b1 : agree_base;
   end

   // state update per transaction
   always_comb begin
      cand_in   = cand_ff;
      agree_in  = agree_ff;
      locked_in = locked_ff;
      nft_in    = nft_ff;
      due       = 1'b0;
      if (take) begin
         if (!item.is_advance) begin
            if (item.invalid) begin
               cand_in   = '0;
               agree_in  = '0;
               locked_in = '0;
               nft_in    = '0;
            end else begin
               cand_in  = item.found;
               agree_in = agree_next;
               if (agree_next >= cfg.promote_count) begin
                  if (locked_ff != item.found) begin
                     nft_in = '0;
                  end
                  locked_in = item.found;
                  agree_in  = cfg.promote_count;
               end
            end
         end else if (locked_ff != '0) begin
            due = (item.repeats >= REPEAT_W'(locked_ff));
         end else if (resync) begin
            if (item.resync_wait) begin
               nft_in = item.tgt_plus_fp;
            end else begin
               due    = 1'b1;
               nft_in = item.resync_step_ok ? item.tgt_plus_2fp : item.tgt_plus_fp;
            end
         end else if (!keep_wait) begin
            due    = 1'b1;
            nft_in = keep_step_ok ? nft_step : item.tgt_plus_fp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff   <= '0;
         agree_ff  <= '0;
         locked_ff <= '0;
         nft_ff    <= '0;
      end else begin
         cand_ff   <= cand_in;
         agree_ff  <= agree_in;
         locked_ff <= locked_in;
         nft_ff    <= nft_in;
      end
   end

   // result of this transaction, state as left by it
   always_comb begin
      rsp.frame_due       = due;
      rsp.locked_divisor  = locked_in;
      rsp.pending_divisor = cand_in;
   end

endmodule

// ===== hw/rtl/rcp_result_queue.sv =====
// result queue that decouples the back end from the consumer
`timescale 1ns / 1ps

module rcp_result_queue
   import rcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_rsp,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type               mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W:0]    count_ff, count_in;

   assign full  = (count_ff == (RSP_PTR_W + 1)'(RSP_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rsp;
      end
   end

endmodule

// ===== hw/rtl/refresh_cadence_pacer.sv =====
// top level of the refresh cadence pacer
// a pushed transaction passes the item queue and the back end into the result queue, then the ports
// throughput: one transaction per cycle; back end retires one per cycle unless rsp queue full
// full rises only when the four-entry front queue fills behind a stalled result side
// reset (synchronous, active high) empties both queues, clears cadence state, reloads registers
`timescale 1ns / 1ps

module refresh_cadence_pacer
   import rcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_opcode,
   input  logic [INTERVAL_W-1:0] req_interval_us,
   input  logic                  req_interval_bad,
   input  logic [TARGET_W-1:0]   req_target_us,
   input  logic [REPEAT_W-1:0]   req_repeat_count,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_frame_due,
   output mult_type              rsp_locked_divisor,
   output mult_type              rsp_pending_divisor,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type  cfg;
   item_type front_item;
   item_type queue_head;
   logic     item_full;
   logic     item_empty;
   logic     item_pop;
   logic     rsp_full;
   logic     rsp_push;
   rsp_type  back_rsp;
   rsp_type  rsp_head;

   // configuration
   rcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // classify incoming transaction
   rcp_front u_front (
      .cfg              (cfg),
      .req_opcode       (req_opcode),
      .req_interval_us  (req_interval_us),
      .req_interval_bad (req_interval_bad),
      .req_target_us    (req_target_us),
      .req_repeat_count (req_repeat_count),
      .item             (front_item)
   );

   rcp_item_queue u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !item_full),
      .push_item (front_item),
      .full      (item_full),
      .pop       (item_pop),
      .empty     (item_empty),
      .head      (queue_head)
   );

   // state update
   rcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (!item_empty),
      .item       (queue_head),
      .item_pop   (item_pop),
      .rsp_ready  (!rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (back_rsp)
   );

   rcp_result_queue u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_rsp (back_rsp),
      .full     (rsp_full),
      .pop      (rsp_pop && !rsp_empty),
      .empty    (rsp_empty),
      .head     (rsp_head)
   );

   assign req_full            = item_full;
   assign rsp_frame_due       = rsp_head.frame_due;
   assign rsp_locked_divisor  = rsp_head.locked_divisor;
   assign rsp_pending_divisor = rsp_head.pending_divisor;

endmodule

// ===== hw/rtl/rcp_checker.sv =====
// port-level checker for the refresh cadence pacer, bound to the top level
`timescale 1ns / 1ps

`include "refresh_cadence_pacer_macros.svh"

module rcp_checker
   import rcp_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_full,
   input logic     rsp_empty,
   input logic     rsp_pop,
   input logic     rsp_frame_due,
   input mult_type rsp_locked_divisor,
   input mult_type rsp_pending_divisor
);

   // reset leaves no result waiting
   `RCP_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, rsp_empty, "result after reset")

   // reset leaves room for a transaction
   `RCP_ASSERT_ALWAYS_NEXT(a_reset_room, reset, !req_full, "full after reset")

   // divisors stay within the multiples tried
   `RCP_ASSERT_NOW(a_divisor_range, !rsp_empty, (rsp_locked_divisor <= MULT_W'(MULT_LIMIT)) && (rsp_pending_divisor <= MULT_W'(MULT_LIMIT)), "divisor out of range")

   // a stalled result holds
   `RCP_ASSERT_NEXT(a_stall_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_frame_due) && $stable(rsp_locked_divisor) && $stable(rsp_pending_divisor), "stalled result changed")

endmodule

bind refresh_cadence_pacer rcp_checker u_checker (.*);
